// ===== hdl/seat_occupancy_debounce_alarm_macros.svh =====
// assertion macros for the checker in soda_checker.sv
`ifndef SEAT_OCCUPANCY_DEBOUNCE_ALARM_MACROS_SVH
`define SEAT_OCCUPANCY_DEBOUNCE_ALARM_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SODA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SODA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/soda_pkg.sv =====
`default_nettype none

package soda_pkg;

  // field widths
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LevelW   = 12;
  localparam int unsigned DeltaW   = 13;
  localparam int unsigned IntervW  = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned LimitW   = CountW + IntervW;
  localparam int unsigned DiffW    = 14;

  // port widths
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_CALIB_DELTA      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DETECT_THRESHOLD = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MEASURE_INTERVAL = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_ON      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_OFF     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ALARM_INTERVAL   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ALARM_ESCALATE   = 3'd6;

  // register reset values
  localparam logic [DeltaW-1:0]  RST_CALIB_DELTA      = 13'd0;
  localparam logic [LevelW-1:0]  RST_DETECT_THRESHOLD = 12'd64;
  localparam logic [IntervW-1:0] RST_MEASURE_INTERVAL = 16'd3;
  localparam logic [CountW-1:0]  RST_DEBOUNCE_ON      = 8'd2;
  localparam logic [CountW-1:0]  RST_DEBOUNCE_OFF     = 8'd5;
  localparam logic [IntervW-1:0] RST_ALARM_INTERVAL   = 16'd900;
  localparam logic [CountW-1:0]  RST_ALARM_ESCALATE   = 8'd4;

  // alarm count limits
  localparam logic [CountW-1:0]  ALARM_COUNT_INIT     = 8'd1;
  localparam logic [CountW-1:0]  ALARM_COUNT_MAX      = 8'd255;

  // alarm kind codes
  localparam logic [KindW-1:0]   ALARM_NONE      = 2'd0;
  localparam logic [KindW-1:0]   ALARM_GENTLE    = 2'd1;
  localparam logic [KindW-1:0]   ALARM_INSISTENT = 2'd2;

  typedef struct packed {
    logic [CountW-1:0] alarm_number;
    logic [KindW-1:0]  alarm_kind;
    logic              state_changed;
    logic              seat_occupied;
    logic              evaluated;
    logic              detected;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/seat_occupancy_debounce_alarm.sv =====
`default_nettype none

// Seat occupancy debounce and sitting alarm. Each input transfer carries a
// time stamp and a sense and a reference reading; each one yields exactly one
// result transfer, in order. A new input transfer is taken every clock cycle
// while the input register can free; the result passes through the input
// register, then the result register. The single pass of compare, debounce
// and alarm logic between those two registers also updates the debounce and
// alarm state in the same cycle that the result register loads. The output
// register frees as soon as out_tready is high, so the stream runs at one
// item per cycle for as long as the consumer keeps up; a stalled consumer
// stalls the input after the input register fills. Registers are to be
// written through cfg_* only while the block is idle; the user is bound to
// this, the block itself does not enforce it. Every write takes effect at
// once. The alarm count never restarts across free periods and saturates at 255.
module seat_occupancy_debounce_alarm
  import soda_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [31:0] now_seconds, [43:32] sense_level, [55:44] ref_level
  input  wire logic [InDataW-1:0]   in_tdata,
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [0] detected, [1] evaluated, [2] seat_occupied, [3] state_changed,
  // [5:4] alarm_kind, [13:6] alarm_number, [15:14] zero
  output logic [OutDataW-1:0]       out_tdata,
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_wdata
);

  // configuration registers
  logic [DeltaW-1:0]  calib_delta_r;
  logic [LevelW-1:0]  detect_threshold_r;
  logic [IntervW-1:0] measure_interval_r;
  logic [CountW-1:0]  debounce_on_r;
  logic [CountW-1:0]  debounce_off_r;
  logic [IntervW-1:0] alarm_interval_r;
  logic [CountW-1:0]  alarm_escalate_r;

  // input register
  logic               s1_valid_r;
  logic [TimeW-1:0]   s1_now_r;
  logic [LevelW-1:0]  s1_sense_r;
  logic [LevelW-1:0]  s1_ref_r;

  // block state
  logic               occupied_r,       occupied_nxt;
  logic [CountW-1:0]  debounce_cnt_r,   debounce_cnt_nxt;
  logic [TimeW-1:0]   last_eval_r,      last_eval_nxt;
  logic [TimeW-1:0]   occupied_since_r, occupied_since_nxt;
  logic [CountW-1:0]  alarm_cnt_r,      alarm_cnt_nxt;

  // result register
  logic               out_valid_r;
  result_t            out_res_r,        out_res_nxt;

  logic               advance;

  // item moves from the input register to the result register
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_res_r};

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_delta_r      <= RST_CALIB_DELTA;
      detect_threshold_r <= RST_DETECT_THRESHOLD;
      measure_interval_r <= RST_MEASURE_INTERVAL;
      debounce_on_r      <= RST_DEBOUNCE_ON;
      debounce_off_r     <= RST_DEBOUNCE_OFF;
      alarm_interval_r   <= RST_ALARM_INTERVAL;
      alarm_escalate_r   <= RST_ALARM_ESCALATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CALIB_DELTA:      calib_delta_r      <= cfg_wdata[DeltaW-1:0];
        REG_DETECT_THRESHOLD: detect_threshold_r <= cfg_wdata[LevelW-1:0];
        REG_MEASURE_INTERVAL: measure_interval_r <= cfg_wdata[IntervW-1:0];
        REG_DEBOUNCE_ON:      debounce_on_r      <= cfg_wdata[CountW-1:0];
        REG_DEBOUNCE_OFF:     debounce_off_r     <= cfg_wdata[CountW-1:0];
        REG_ALARM_INTERVAL:   alarm_interval_r   <= cfg_wdata[IntervW-1:0];
        REG_ALARM_ESCALATE:   alarm_escalate_r   <= cfg_wdata[CountW-1:0];
        default: ; // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // single pass: detect, interval check, debounce, alarm
  // ---------------------------------------------------------------------
  logic signed [DiffW-1:0]  reading_diff;
  logic signed [DiffW-1:0]  detect_limit;
  logic                     detected;
  logic [TimeW-1:0]         since_eval;
  logic                     elapsed;
  logic                     disagree;
  logic [CountW-1:0]        need;
  logic [CountW-1:0]        cnt_inc;
  logic                     flip;
  logic [LimitW-1:0]        alarm_limit;
  logic [TimeW-1:0]         sit_time;
  logic                     alarm_fire;
  logic [CountW-1:0]        alarm_inc;

  always_comb begin
    // presence: sense - ref below calib_delta - threshold, all signed
    reading_diff = $signed({2'b00, s1_sense_r}) - $signed({2'b00, s1_ref_r});
    detect_limit = $signed({calib_delta_r[DeltaW-1], calib_delta_r})
                 - $signed({2'b00, detect_threshold_r});
    detected     = reading_diff < detect_limit;

    // wrapping time since the last evaluation
    since_eval = s1_now_r - last_eval_r;
    elapsed    = since_eval >= {{(TimeW - IntervW){1'b0}}, measure_interval_r};

    // debounce only counts readings that disagree with the held state;
    // a required count of zero behaves like one
    disagree = detected ? !occupied_r : occupied_r;
    need     = detected ? debounce_on_r : debounce_off_r;
    cnt_inc  = debounce_cnt_r + 8'd1;
    flip     = elapsed && disagree && (cnt_inc >= need);

    // alarm: only while the seat stays occupied through this evaluation;
    // a seat that just became occupied has zero sitting time anyway
    alarm_limit = alarm_cnt_r * alarm_interval_r;
    sit_time    = s1_now_r - occupied_since_r;
    alarm_fire  = elapsed && occupied_r && !flip
               && (alarm_cnt_r != ALARM_COUNT_MAX)
               && (sit_time > {{(TimeW - LimitW){1'b0}}, alarm_limit});
    alarm_inc   = alarm_cnt_r + 8'd1;

    occupied_nxt       = occupied_r;
    debounce_cnt_nxt   = debounce_cnt_r;
    last_eval_nxt      = last_eval_r;
    occupied_since_nxt = occupied_since_r;
    alarm_cnt_nxt      = alarm_cnt_r;

    if (elapsed) begin
      last_eval_nxt = s1_now_r;
      if (!disagree) begin
        debounce_cnt_nxt = '0;
      end else if (flip) begin
        debounce_cnt_nxt = '0;
        occupied_nxt     = !occupied_r;
        if (detected) begin
          occupied_since_nxt = s1_now_r;
        end
      end else begin
        debounce_cnt_nxt = cnt_inc;
      end
    end
    if (alarm_fire) begin
      alarm_cnt_nxt = alarm_inc;
    end

    out_res_nxt.detected      = detected;
    out_res_nxt.evaluated     = elapsed;
    out_res_nxt.seat_occupied = occupied_nxt;
    out_res_nxt.state_changed = flip;
    out_res_nxt.alarm_number  = alarm_cnt_nxt;
    if (!alarm_fire) begin
      out_res_nxt.alarm_kind = ALARM_NONE;
    end else if (alarm_inc > alarm_escalate_r) begin
      out_res_nxt.alarm_kind = ALARM_INSISTENT;
    end else begin
      out_res_nxt.alarm_kind = ALARM_GENTLE;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      occupied_r       <= 1'b0;
      debounce_cnt_r   <= '0;
      last_eval_r      <= '0;
      occupied_since_r <= '0;
      alarm_cnt_r      <= ALARM_COUNT_INIT;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r      <= 1'b1;
        occupied_r       <= occupied_nxt;
        debounce_cnt_r   <= debounce_cnt_nxt;
        last_eval_r      <= last_eval_nxt;
        occupied_since_r <= occupied_since_nxt;
        alarm_cnt_r      <= alarm_cnt_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_now_r   <= in_tdata[TimeW-1:0];
      s1_sense_r <= in_tdata[TimeW +: LevelW];
      s1_ref_r   <= in_tdata[TimeW + LevelW +: LevelW];
    end
    if (advance) begin
      out_res_r <= out_res_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/soda_checker.sv =====
`default_nettype none

`include "seat_occupancy_debounce_alarm_macros.svh"

module soda_checker
  import soda_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata
);

  result_t res;
  assign res = out_tdata[$bits(result_t)-1:0];

  // stalled result holds
  `SODA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // a state toggle only comes from an evaluation
  `SODA_ASSERT_IMP(a_change_eval, out_tvalid && res.state_changed, res.evaluated, "state change without evaluation")

  // alarms need an evaluation with the seat occupied
  `SODA_ASSERT_IMP(a_alarm_occ, out_tvalid && (res.alarm_kind != ALARM_NONE), res.evaluated && res.seat_occupied, "alarm without occupied evaluation")

  // an alarm advances the count past its initial value
  `SODA_ASSERT_IMP(a_alarm_count, out_tvalid && (res.alarm_kind != ALARM_NONE), res.alarm_number > ALARM_COUNT_INIT, "alarm without advanced count")

endmodule

bind seat_occupancy_debounce_alarm soda_checker u_soda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/seat_occupancy_debounce_alarm_checker.sv =====
`timescale 1ns / 100ps

module seat_occupancy_debounce_alarm_checker
  import soda_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  // [31:0] now_seconds, [43:32] sense_level, [55:44] ref_level
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  // [0] detected, [1] evaluated, [2] seat_occupied, [3] state_changed,
  // [5:4] alarm_kind, [13:6] alarm_number, [15:14] zero
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  reports_due,
  output int                  reports_checked,
  output int                  toggles_seen,
  output int                  alarms_seen
);

  localparam int RepW = $bits(result_t);

  // settings mirror
  logic signed [DeltaW-1:0] cal_delta;
  logic [LevelW-1:0]        thresh;
  logic [IntervW-1:0]       meas_ivl;
  logic [CountW-1:0]        on_need;
  logic [CountW-1:0]        off_need;
  logic [IntervW-1:0]       alarm_ivl;
  logic [CountW-1:0]        escalate;

  // occupancy state mirror
  logic                     seat_taken;
  logic [CountW-1:0]        streak;
  logic [TimeW-1:0]         last_eval;
  logic [TimeW-1:0]         sat_since;
  logic [CountW-1:0]        alarm_cnt;

  result_t awaited_reports[$];
  int n_checked = 0;
  int n_toggles = 0;
  int n_alarms  = 0;

  function automatic result_t judge_reading(logic [TimeW-1:0] now,
                                            logic [LevelW-1:0] sense,
                                            logic [LevelW-1:0] refl);
    result_t rep;
    int level_gap;
    int bound;
    logic [TimeW-1:0] limit;
    rep = '0;
    level_gap = int'(sense) - int'(refl);
    bound = int'(cal_delta) - int'(thresh);
    rep.detected = (level_gap < bound);
    if (now - last_eval >= meas_ivl) begin
      rep.evaluated = 1'b1;
      last_eval = now;
      if (rep.detected != seat_taken) begin
        streak = streak + 1'b1;
        if (streak >= (rep.detected ? on_need : off_need)) begin
          streak = '0;
          seat_taken = rep.detected;
          if (rep.detected) sat_since = now;
          rep.state_changed = 1'b1;
        end
      end else begin
        streak = '0;
      end
      if (seat_taken && alarm_cnt != ALARM_COUNT_MAX) begin
        limit = alarm_cnt * alarm_ivl;  // full width product
        if (now - sat_since > limit) begin
          alarm_cnt = alarm_cnt + 1'b1;
          rep.alarm_kind = (alarm_cnt > escalate) ? ALARM_INSISTENT : ALARM_GENTLE;
        end
      end
    end
    rep.seat_occupied = seat_taken;
    rep.alarm_number = alarm_cnt;
    return rep;
  endfunction

  function automatic int field_differs(string label, int want, int got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    result_t exp_r;
    result_t got_r;
    int bad;
    bad = 0;
    if (!rst_n) begin
      cal_delta  = RST_CALIB_DELTA;
      thresh     = RST_DETECT_THRESHOLD;
      meas_ivl   = RST_MEASURE_INTERVAL;
      on_need    = RST_DEBOUNCE_ON;
      off_need   = RST_DEBOUNCE_OFF;
      alarm_ivl  = RST_ALARM_INTERVAL;
      escalate   = RST_ALARM_ESCALATE;
      seat_taken = 1'b0;
      streak     = '0;
      last_eval  = '0;
      sat_since  = '0;
      alarm_cnt  = ALARM_COUNT_INIT;
      awaited_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CALIB_DELTA:      cal_delta = cfg_wdata[DeltaW-1:0];
          REG_DETECT_THRESHOLD: thresh    = cfg_wdata[LevelW-1:0];
          REG_MEASURE_INTERVAL: meas_ivl  = cfg_wdata[IntervW-1:0];
          REG_DEBOUNCE_ON:      on_need   = cfg_wdata[CountW-1:0];
          REG_DEBOUNCE_OFF:     off_need  = cfg_wdata[CountW-1:0];
          REG_ALARM_INTERVAL:   alarm_ivl = cfg_wdata[IntervW-1:0];
          REG_ALARM_ESCALATE:   escalate  = cfg_wdata[CountW-1:0];
          default: ;
        endcase
      end
      // results leave before the transfer taken at this edge can produce one
      if (out_tvalid && out_tready) begin
        got_r = result_t'(out_tdata[RepW-1:0]);
        if (awaited_reports.size() == 0) begin
          $display("%0t: result 0x%h arrived with none expected", $time, out_tdata);
          bad++;
        end else begin
          exp_r = awaited_reports.pop_front();
          bad += field_differs("detected", exp_r.detected, got_r.detected);
          bad += field_differs("evaluated", exp_r.evaluated, got_r.evaluated);
          bad += field_differs("seat_occupied", exp_r.seat_occupied, got_r.seat_occupied);
          bad += field_differs("state_changed", exp_r.state_changed, got_r.state_changed);
          bad += field_differs("alarm_kind", exp_r.alarm_kind, got_r.alarm_kind);
          bad += field_differs("alarm_number", exp_r.alarm_number, got_r.alarm_number);
          bad += field_differs("pad bits", 0, int'(out_tdata[OutDataW-1:RepW]));
          n_checked++;
          if (exp_r.state_changed) n_toggles++;
          if (exp_r.alarm_kind != ALARM_NONE) n_alarms++;
        end
      end
      if (in_tvalid && in_tready)
        awaited_reports.push_back(judge_reading(in_tdata[31:0], in_tdata[43:32],
                                                in_tdata[55:44]));
    end
    mismatches      <= mismatches + bad;
    reports_due     <= awaited_reports.size();
    reports_checked <= n_checked;
    toggles_seen    <= n_toggles;
    alarms_seen     <= n_alarms;
  end

endmodule

// ===== tb/tb_seat_occupancy_debounce_alarm.sv =====
`timescale 1ns / 100ps

module tb_seat_occupancy_debounce_alarm;
  import soda_pkg::*;

  // cycles with no transfer at all before the run is declared hung;
  // well above the long receiver hold and the longest sender gap
  localparam int WatchdogLimit = 3000;
  // receiver hold-off used to back the block up into its input
  localparam int LongHold      = 200;
  // slack after the last result
  localparam int DrainSlack    = 8;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  // [31:0] now_seconds, [43:32] sense_level, [55:44] ref_level
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [0] detected, [1] evaluated, [2] seat_occupied, [3] state_changed,
  // [5:4] alarm_kind, [13:6] alarm_number, [15:14] zero
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = REG_CALIB_DELTA;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  int mismatches;
  int reports_due;
  int reports_checked;
  int toggles_seen;
  int alarms_seen;

  // current settings as seen by the stimulus, only used to aim readings at the
  // detection bound, to size the reading runs and to pace the time stamps
  int cur_calib  = int'($signed(RST_CALIB_DELTA));
  int cur_thresh = int'(RST_DETECT_THRESHOLD);
  int cur_meas   = int'(RST_MEASURE_INTERVAL);
  int cur_on     = int'(RST_DEBOUNCE_ON);
  int cur_off    = int'(RST_DEBOUNCE_OFF);

  logic [TimeW-1:0] wall_clock = '0;
  bit no_gaps        = 1'b0;
  bit hold_request   = 1'b0;
  int readings_sent  = 0;
  int settings_used  = 1;
  int quiet_cycles   = 0;

  seat_occupancy_debounce_alarm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  seat_occupancy_debounce_alarm_checker occupancy_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .reports_due     (reports_due),
    .reports_checked (reports_checked),
    .toggles_seen    (toggles_seen),
    .alarms_seen     (alarms_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang detection: any transfer on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, reports_due);
      $display("tb_seat_occupancy_debounce_alarm: FAIL");
      $finish;
    end
  end

  // result side: short random stalls, the odd long one, calm stretches with
  // ready held high, and one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int calm_left;
    int r;
    stall_left = 0;
    calm_left  = 0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else begin
        if (stall_left > 0) begin
          out_tready <= 1'b0;
          stall_left--;
        end else begin
          out_tready <= 1'b1;
          if (calm_left > 0) begin
            calm_left--;
          end else begin
            r = $urandom_range(0, 99);
            if (r < 25) stall_left = $urandom_range(1, 3);
            else if (r < 28) stall_left = $urandom_range(8, 40);
            else if (r < 30) calm_left = $urandom_range(50, 200);
          end
        end
        @(posedge clk);
      end
    end
  end

  // sender idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one input transfer; entered and left just after a rising edge
  task automatic send_reading(input logic [TimeW-1:0] stamp,
                              input logic [LevelW-1:0] sense,
                              input logic [LevelW-1:0] refl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {refl, sense, stamp};
    do @(posedge clk); while (!in_tready);
    readings_sent++;
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CfgDataW-1:0];
    @(posedge clk);
  endtask

  // rewrite all seven registers; only called with the block drained
  task automatic apply_settings(input int calib, input int thresh, input int meas,
                                input int on_cnt, input int off_cnt, input int alarm_ivl,
                                input int esc);
    write_register(REG_CALIB_DELTA, calib);
    write_register(REG_DETECT_THRESHOLD, thresh);
    write_register(REG_MEASURE_INTERVAL, meas);
    write_register(REG_DEBOUNCE_ON, on_cnt);
    write_register(REG_DEBOUNCE_OFF, off_cnt);
    write_register(REG_ALARM_INTERVAL, alarm_ivl);
    write_register(REG_ALARM_ESCALATE, esc);
    cfg_we <= 1'b0;
    cur_calib  = calib;
    cur_thresh = thresh;
    cur_meas   = meas;
    cur_on     = on_cnt;
    cur_off    = off_cnt;
    settings_used++;
  endtask

  // pick a sense/reference pair on the wanted side of the detection bound,
  // often right at it; now and then a fully random pair as noise
  task automatic make_reading(input bit present, output logic [LevelW-1:0] sense,
                              output logic [LevelW-1:0] refl);
    int bound;
    int lo;
    int hi;
    int diff;
    int rlo;
    int rhi;
    bound = cur_calib - cur_thresh;
    if (present) begin
      lo = (bound - 200 > -4095) ? bound - 200 : -4095;
      hi = bound - 1;
    end else begin
      lo = (bound > -4095) ? bound : -4095;
      hi = (bound + 200 < 4095) ? bound + 200 : 4095;
    end
    if (lo > hi || $urandom_range(0, 9) == 0)
      diff = int'($urandom_range(0, 8190)) - 4095;
    else if ($urandom_range(0, 3) == 0)
      diff = present ? hi : lo;
    else
      diff = lo + int'($urandom_range(0, hi - lo));
    rlo = (diff < 0) ? -diff : 0;
    rhi = (diff > 0) ? 4095 - diff : 4095;
    refl  = LevelW'(rlo + int'($urandom_range(0, rhi - rlo)));
    sense = LevelW'(int'(refl) + diff);
  endtask

  // mostly one measure interval ahead so the debounce runs, sometimes too
  // early to evaluate, sometimes a long jump, and rarely anywhere at all
  function automatic logic [TimeW-1:0] next_stamp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return wall_clock + cur_meas + $urandom_range(0, 3);
    if (r < 85) return wall_clock + $urandom_range(0, cur_meas);
    if (r < 96) return wall_clock + cur_meas * $urandom_range(2, 30) + $urandom_range(0, 5000);
    return $urandom();
  endfunction

  // runs of readings that agree, each long enough to often reach the
  // debounce count, with the odd contrary reading that breaks the run
  task automatic run_random(input int count);
    int done_items;
    int run_len;
    int need;
    int k;
    bit present;
    logic [LevelW-1:0] sense;
    logic [LevelW-1:0] refl;
    done_items = 0;
    while (done_items < count) begin
      present = $urandom_range(0, 1);
      need = present ? cur_on : cur_off;
      run_len = $urandom_range(1, (need < 1 ? 1 : need) + 2);
      for (k = 0; k < run_len && done_items < count; k++) begin
        make_reading(($urandom_range(0, 19) == 0) ? !present : present, sense, refl);
        wall_clock = next_stamp();
        send_reading(wall_clock, sense, refl);
        done_items++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: bound is -64, evaluation every 3 s, on 2, off 5
    send_reading(32'd0, 12'd0, 12'd0);            // too early, not detected
    send_reading(32'd1, 12'd0, 12'd4095);         // detected but no evaluation
    send_reading(32'd3, 12'd4095, 12'd0);         // absent while free clears
    send_reading(32'd6, 12'd100, 12'd1000);       // first detected evaluation
    send_reading(32'd9, 12'd2000, 12'd2000);      // agreeing reading clears
    send_reading(32'd12, 12'd100, 12'd1000);
    send_reading(32'd15, 12'd100, 12'd1000);      // becomes occupied
    send_reading(32'd16, 12'd100, 12'd1000);      // no evaluation
    send_reading(32'd18, 12'd100, 12'd1000);      // detected while occupied
    send_reading(32'd1000, 12'd100, 12'd1000);    // first alarm, gentle
    send_reading(32'hFFFF_FFFF, 12'd4095, 12'd4095); // top of time range
    send_reading(32'd2, 12'd2000, 12'd2000);      // interval across the wrap
    send_reading(32'd5, 12'd2000, 12'd2000);      // alarms turn insistent
    send_reading(32'd8, 12'd2000, 12'd2000);
    send_reading(32'd11, 12'd2000, 12'd2000);     // off count reached, free
    drain();

    // zero debounce counts act like one
    apply_settings(int'($signed(RST_CALIB_DELTA)), int'(RST_DETECT_THRESHOLD),
                   int'(RST_MEASURE_INTERVAL), 0, 0, int'(RST_ALARM_INTERVAL),
                   int'(RST_ALARM_ESCALATE));
    send_reading(32'd14, 12'd100, 12'd1000);
    send_reading(32'd17, 12'd2000, 12'd2000);
    send_reading(32'd20, 12'd100, 12'd1000);
    send_reading(32'd23, 12'd100, 12'd1000);
    wall_clock = 32'd23;
    drain();

    // reset-like settings with a short alarm step
    apply_settings(0, 64, 3, 2, 5, 20, 4);
    run_random(350);
    drain();

    // bound at -4095: nothing can be detected, every reading evaluated
    apply_settings(-4095, 0, 0, 1, 1, 50, 255);
    run_random(100);
    drain();

    // highest values but for escalate: longest interval, widest alarm product
    apply_settings(4095, 4095, 65535, 255, 255, 65535, 0);
    run_random(300);
    drain();

    // zero debounce counts under random readings
    apply_settings(300, 200, 7, 0, 0, 30, 60);
    run_random(250);
    drain();

    // random settings, sender never idles and the receiver holds off once
    apply_settings(int'($urandom_range(0, 4000)) - 2000, $urandom_range(0, 1000),
                   $urandom_range(1, 20), $urandom_range(1, 6), $urandom_range(1, 6),
                   $urandom_range(10, 2000), $urandom_range(0, 255));
    no_gaps = 1'b1;
    hold_request = 1'b1;
    run_random(400);
    no_gaps = 1'b0;
    drain();

    apply_settings(int'($urandom_range(0, 8190)) - 4095, $urandom_range(0, 4095),
                   $urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 8),
                   $urandom_range(5, 500), $urandom_range(0, 255));
    run_random(300);
    drain();

    // zero alarm step and a sticky seat: the alarm count runs up to saturation
    apply_settings(-100, 50, 1, 1, 255, 0, 200);
    run_random(450);
    drain();

    $display("covered %0d readings under %0d register settings, %0d results checked",
             readings_sent, settings_used, reports_checked);
    $display("with %0d occupancy changes and %0d alarms raised", toggles_seen, alarms_seen);
    if (mismatches == 0)
      $display("tb_seat_occupancy_debounce_alarm: PASS");
    else
      $display("tb_seat_occupancy_debounce_alarm: FAIL");
    $finish;
  end

endmodule
